FILE: rtl/core/hue_gradient_to_rgb_unit_defines.svh
// Assertion macros for the hue gradient to RGB unit.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef HUE_GRADIENT_TO_RGB_UNIT_DEFINES_SVH
`define HUE_GRADIENT_TO_RGB_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define HGR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HGR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hgr_pkg.sv
// Shared types and constants for the hue gradient to RGB unit.
// No dependencies; imported by the channel slice, the top level and the checker.
`default_nettype none

package hgr_pkg;

    // Sizing
    localparam int MAX_HUES  = 8;
    localparam int HUE_BITS  = 16;
    localparam int POS_W     = 16;
    localparam int LVL_W     = 8;
    localparam int CNT_W     = 4;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int STOP_W    = 16;
    localparam int TBL_STOPS = CFG_W / STOP_W * 2;
    localparam int TBL_IDX_W = $clog2(TBL_STOPS);
    localparam int IDX_W     = $clog2(MAX_HUES);
    localparam int HUE_W     = STOP_W + 1;   // 0.16 hue, 0 to 1.0 inclusive
    localparam int T_W       = HUE_W + 1;    // hue times three
    localparam int CH_W      = 16;           // q and p in 1/65025 units
    localparam int NUM_STG   = 6;

    // Stop masking: keep the top HUE_BITS of each stop
    localparam logic [STOP_W-1:0] HUE_MASK =
        STOP_W'(((1 << HUE_BITS) - 1) << (STOP_W - HUE_BITS));
    localparam logic [HUE_W-1:0] HUE_ONE = HUE_W'(1 << STOP_W);

    // Circle positions in units of 1/196608
    localparam logic [T_W-1:0] SIXTH3     = T_W'(32768);
    localparam logic [T_W-1:0] THIRD3     = T_W'(65536);
    localparam logic [T_W-1:0] HALF3      = T_W'(98304);
    localparam logic [T_W-1:0] TWOTHIRDS3 = T_W'(131072);
    localparam int SIXTH_SHIFT = 15;

    // floor(v / 255) = (v * 32897) >> 23 for v up to 65025
    localparam int RECIP_SHIFT = 23;
    localparam logic [CH_W-1:0] RECIP_255 = CH_W'(((1 << RECIP_SHIFT) + 254) / 255);

    // Register defaults
    localparam logic [LVL_W-1:0] SAT_RST   = LVL_W'(255);
    localparam logic [LVL_W-1:0] LIGHT_RST = LVL_W'(128);
    localparam logic [CNT_W-1:0] COUNT_RST = CNT_W'(1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SATURATION = 3'd0,
        REG_LIGHTNESS  = 3'd1,
        REG_HUE_COUNT  = 3'd2,
        REG_TABLE_LOW  = 3'd3,
        REG_TABLE_HIGH = 3'd4
    } cfg_reg_t;

    // Load enables for the two stages inside a channel slice
    typedef struct packed {
        logic ld_mul;
        logic ld_div;
    } hgr_ch_en_t;

endpackage

`default_nettype wire

FILE: rtl/core/hue_gradient_to_rgb_unit.sv
// Hue gradient to RGB: position -> interpolated hue -> HSL to 8-bit RGB.
// Depends on hgr_pkg and hgr_channel.
//
//   port group   dir   handshake         payload
//   s_*          in    s_valid/s_ready   s_position[15:0]
//   m_*          out   m_valid/m_ready   m_red_level, m_green_level, m_blue_level
//   cfg_*        in    cfg_wr_en         cfg_index[2:0], cfg_wr_data[63:0]
//
// One item per clock when the output is not stalled; six register stages, the
// last being the output register.
// Each stage holds its own valid bit and takes a new item whenever it is empty
// or the stage after it moves, so bubbles close up under a stall.
// q/p terms follow a configuration write through the ls/l255/s255 and q/p/d registers.
// Reset (aresetn, synchronous) empties the pipeline and loads register defaults.
`default_nettype none

module hue_gradient_to_rgb_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hgr_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hgr_pkg::POS_W-1:0]     s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hgr_pkg::LVL_W-1:0]     m_red_level,
    output logic [hgr_pkg::LVL_W-1:0]     m_green_level,
    output logic [hgr_pkg::LVL_W-1:0]     m_blue_level
);
    import hgr_pkg::*;

    // Configuration registers
    logic [LVL_W-1:0] sat_reg;
    logic [LVL_W-1:0] light_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CFG_W-1:0] tbl_lo_reg;
    logic [CFG_W-1:0] tbl_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg    <= SAT_RST;
            light_reg  <= LIGHT_RST;
            count_reg  <= COUNT_RST;
            tbl_lo_reg <= '0;
            tbl_hi_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_SATURATION: sat_reg    <= cfg_wr_data[LVL_W-1:0];
                REG_LIGHTNESS:  light_reg  <= cfg_wr_data[LVL_W-1:0];
                REG_HUE_COUNT:  count_reg  <= cfg_wr_data[CNT_W-1:0];
                REG_TABLE_LOW:  tbl_lo_reg <= cfg_wr_data;
                REG_TABLE_HIGH: tbl_hi_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // q, p and q - p from saturation and lightness, two register levels
    logic [CH_W-1:0] ls_reg;
    logic [CH_W-1:0] l255_reg;
    logic [CH_W-1:0] s255_reg;
    logic            lhi_reg;
    logic [CH_W-1:0] q_reg;
    logic [CH_W-1:0] p_reg;
    logic [CH_W-1:0] d_reg;
    logic [CH_W-1:0] q_next;
    logic [CH_W-1:0] d_next;

    always_ff @(posedge aclk) begin
        ls_reg   <= light_reg * sat_reg;
        l255_reg <= {light_reg, {LVL_W{1'b0}}} - CH_W'(light_reg);
        s255_reg <= {sat_reg, {LVL_W{1'b0}}} - CH_W'(sat_reg);
        lhi_reg  <= light_reg[LVL_W-1];
    end

    always_comb begin
        if (!lhi_reg) begin
            q_next = l255_reg + ls_reg;
            d_next = {ls_reg[CH_W-2:0], 1'b0};
        end else begin
            q_next = CH_W'({1'b0, l255_reg} + {1'b0, s255_reg} - {1'b0, ls_reg});
            d_next = CH_W'({s255_reg - ls_reg, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        d_reg <= d_next;
        p_reg <= q_next - d_next;
    end

    // Pipeline valid/ready chain; index 0 is the input port
    logic [NUM_STG:1]   vld_reg;
    logic [NUM_STG:0]   vld_w;
    logic [NUM_STG+1:1] rdy_w;

    assign vld_w = {vld_reg, s_valid};

    always_comb begin
        rdy_w[NUM_STG+1] = m_ready;
        for (int k = NUM_STG; k >= 1; k--) begin
            rdy_w[k] = !vld_reg[k] || rdy_w[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 1; k <= NUM_STG; k++) begin
                if (rdy_w[k]) begin
                    vld_reg[k] <= vld_w[k-1];
                end
            end
        end
    end

    assign s_ready = rdy_w[1];
    assign m_valid = vld_reg[NUM_STG];

    // Stage 1: segment index, fraction, and the two bounding stops
    logic [CNT_W-1:0]       n_w;
    logic [POS_W+CNT_W-1:0] seg_prod;
    logic [IDX_W-1:0]       idx_w;
    logic [STOP_W-1:0]      stop_w [TBL_STOPS];
    logic [STOP_W-1:0]      next_w [TBL_STOPS];
    logic [POS_W-1:0]       frac1_reg;
    logic [STOP_W-1:0]      a1_reg;
    logic [STOP_W-1:0]      b1_reg;

    always_comb begin
        if (count_reg == '0) begin
            n_w = CNT_W'(1);
        end else if (count_reg > CNT_W'(MAX_HUES)) begin
            n_w = CNT_W'(MAX_HUES);
        end else begin
            n_w = count_reg;
        end
        seg_prod = s_position * n_w;
        idx_w    = seg_prod[POS_W +: IDX_W];
    end

    // Stop unpacking; next_w[i] is the stop after i, wrapping at the count
    always_comb begin
        for (int i = 0; i < TBL_STOPS; i++) begin
            if (i < TBL_STOPS / 2) begin
                stop_w[i] = tbl_lo_reg[STOP_W*i +: STOP_W] & HUE_MASK;
            end else begin
                stop_w[i] = tbl_hi_reg[STOP_W*(i - TBL_STOPS/2) +: STOP_W] & HUE_MASK;
            end
        end
        for (int i = 0; i < TBL_STOPS; i++) begin
            if (CNT_W'(i + 1) == n_w) begin
                next_w[i] = stop_w[0];
            end else begin
                next_w[i] = stop_w[(i + 1) % TBL_STOPS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_w[1]) begin
            frac1_reg <= seg_prod[POS_W-1:0];
            a1_reg    <= stop_w[TBL_IDX_W'(idx_w)];
            b1_reg    <= next_w[TBL_IDX_W'(idx_w)];
        end
    end

    // Stage 2: forward distance around the circle times fraction
    logic [STOP_W-1:0]        diff_w;
    logic [POS_W+STOP_W-1:0]  mix_w;
    logic [STOP_W-1:0]        a2_reg;
    logic [STOP_W-1:0]        m2_reg;
    logic                     wrap2_reg;

    // modulo-2^16 difference is b - a, or 65536 - a + b when b < a
    assign diff_w = b1_reg - a1_reg;
    assign mix_w  = frac1_reg * diff_w;

    always_ff @(posedge aclk) begin
        if (rdy_w[2]) begin
            a2_reg    <= a1_reg;
            m2_reg    <= mix_w[POS_W+STOP_W-1:POS_W];
            wrap2_reg <= b1_reg < a1_reg;
        end
    end

    // Stage 3: hue, wrapped back below one when it ran past
    logic [HUE_W-1:0] hsum_w;
    logic [HUE_W-1:0] hue3_reg;

    assign hsum_w = {1'b0, a2_reg} + {1'b0, m2_reg};

    always_ff @(posedge aclk) begin
        if (rdy_w[3]) begin
            if (wrap2_reg && (hsum_w > HUE_ONE)) begin
                hue3_reg <= hsum_w - HUE_ONE;
            end else begin
                hue3_reg <= hsum_w;
            end
        end
    end

    // Stage 4: per-channel circle positions, 3*hue shifted by +-1/3
    logic [T_W-1:0] t3_w;
    logic [T_W-1:0] tr_next;
    logic [T_W-1:0] tb_next;
    logic [T_W-1:0] tr4_reg;
    logic [T_W-1:0] tg4_reg;
    logic [T_W-1:0] tb4_reg;

    always_comb begin
        t3_w = T_W'(hue3_reg) + T_W'({hue3_reg, 1'b0});
        if (t3_w > TWOTHIRDS3) begin
            tr_next = t3_w - TWOTHIRDS3;
        end else begin
            tr_next = t3_w + THIRD3;
        end
        if (t3_w < THIRD3) begin
            tb_next = t3_w + TWOTHIRDS3;
        end else begin
            tb_next = t3_w - THIRD3;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_w[4]) begin
            tr4_reg <= tr_next;
            tg4_reg <= t3_w;
            tb4_reg <= tb_next;
        end
    end

    // Stages 5 and 6: channel slices
    hgr_ch_en_t       ch_en;
    logic [LVL_W-1:0] red_w;
    logic [LVL_W-1:0] green_w;
    logic [LVL_W-1:0] blue_w;

    assign ch_en.ld_mul = rdy_w[5];
    assign ch_en.ld_div = rdy_w[6];

    hgr_channel u_red (
        .aclk  (aclk),
        .en    (ch_en),
        .t_pos (tr4_reg),
        .q_val (q_reg),
        .p_val (p_reg),
        .d_val (d_reg),
        .level (red_w)
    );

    hgr_channel u_green (
        .aclk  (aclk),
        .en    (ch_en),
        .t_pos (tg4_reg),
        .q_val (q_reg),
        .p_val (p_reg),
        .d_val (d_reg),
        .level (green_w)
    );

    hgr_channel u_blue (
        .aclk  (aclk),
        .en    (ch_en),
        .t_pos (tb4_reg),
        .q_val (q_reg),
        .p_val (p_reg),
        .d_val (d_reg),
        .level (blue_w)
    );

    // Zero saturation gives grey at the lightness level
    assign m_red_level   = (sat_reg == '0) ? light_reg : red_w;
    assign m_green_level = (sat_reg == '0) ? light_reg : green_w;
    assign m_blue_level  = (sat_reg == '0) ? light_reg : blue_w;

endmodule

`default_nettype wire

FILE: rtl/core/hgr_channel.sv
// One color channel: hue position to 8-bit level, two pipeline stages.
// Depends on hgr_pkg.
`default_nettype none

module hgr_channel (
    input  logic                    aclk,
    input  hgr_pkg::hgr_ch_en_t     en,
    input  logic [hgr_pkg::T_W-1:0] t_pos,
    input  logic [hgr_pkg::CH_W-1:0] q_val,
    input  logic [hgr_pkg::CH_W-1:0] p_val,
    input  logic [hgr_pkg::CH_W-1:0] d_val,
    output logic [hgr_pkg::LVL_W-1:0] level
);
    import hgr_pkg::*;

    logic [CH_W-1:0]   base_next;
    logic [CH_W-1:0]   ramp_next;
    logic [T_W-1:0]    down_w;
    logic [CH_W-1:0]   base_reg;
    logic [2*CH_W-1:0] prod_reg;
    logic [CH_W:0]     v_w;
    logic [CH_W+CH_W:0] quo_w;
    logic [LVL_W-1:0]  level_reg;

    // Region select: rising ramp, flat q, falling ramp, flat p
    always_comb begin
        down_w    = TWOTHIRDS3 - t_pos;
        base_next = p_val;
        ramp_next = '0;
        if (t_pos < SIXTH3) begin
            ramp_next = t_pos[CH_W-1:0];
        end else if (t_pos < HALF3) begin
            base_next = q_val;
        end else if (t_pos < TWOTHIRDS3) begin
            ramp_next = down_w[CH_W-1:0];
        end
    end

    // Stage A: ramp product (q - p) * x
    always_ff @(posedge aclk) begin
        if (en.ld_mul) begin
            base_reg <= base_next;
            prod_reg <= d_val * ramp_next;
        end
    end

    // Stage B: scale back to 1/65025 units, then divide by 255
    assign v_w   = {1'b0, base_reg} + prod_reg[2*CH_W-1:SIXTH_SHIFT];
    assign quo_w = v_w * RECIP_255;

    always_ff @(posedge aclk) begin
        if (en.ld_div) begin
            level_reg <= quo_w[RECIP_SHIFT +: LVL_W];
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hgr_checker.sv
// Port-level checks for the hue gradient to RGB unit, bound to the top level.
// Depends on hgr_pkg and hue_gradient_to_rgb_unit_defines.svh.
`default_nettype none

`include "hue_gradient_to_rgb_unit_defines.svh"

module hgr_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hgr_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [hgr_pkg::POS_W-1:0]     s_position,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [hgr_pkg::LVL_W-1:0]     m_red_level,
    input  logic [hgr_pkg::LVL_W-1:0]     m_green_level,
    input  logic [hgr_pkg::LVL_W-1:0]     m_blue_level
);
    import hgr_pkg::*;

    localparam int OCC_W = $clog2(NUM_STG + 1) + 1;

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic [LVL_W-1:0] sat_reg;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Items accepted but not yet delivered
    always_comb begin
        occ_next = occ_reg;
        if (in_acc && !out_acc) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (out_acc && !in_acc) begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            sat_reg <= SAT_RST;
        end else begin
            occ_reg <= occ_next;
            if (cfg_wr_en && (cfg_reg_t'(cfg_index) == REG_SATURATION)) begin
                sat_reg <= cfg_wr_data[LVL_W-1:0];
            end
        end
    end

    `HGR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_red_level) && $stable(m_green_level) && $stable(m_blue_level), "result item changed while stalled")
    `HGR_ASSERT_NOW(a_no_block, aclk, aresetn, m_ready, s_ready, "input stalled while output sink is ready")
    `HGR_ASSERT_NOW(a_occupancy, aclk, aresetn, m_valid, (occ_reg != '0) && (occ_reg <= OCC_W'(NUM_STG)), "result item without matching input item")
    `HGR_ASSERT_NOW(a_grey, aclk, aresetn, m_valid && (sat_reg == '0), (m_red_level == m_green_level) && (m_green_level == m_blue_level), "zero saturation did not give grey")

endmodule

bind hue_gradient_to_rgb_unit hgr_checker u_hgr_checker (.*);

`default_nettype wire

FILE: sim/tb_hue_gradient_to_rgb_unit.sv
// Self-checking testbench for hue_gradient_to_rgb_unit: directed and random positions
// under random stalls, results predicted in the bench. Depends on hgr_pkg and the RTL.
`timescale 1ns / 1ps

module tb_hue_gradient_to_rgb_unit;
    import hgr_pkg::*;

    // Hue circle positions in units of 1/196608 (three times the 0.16 hue)
    localparam longint ARC_CIRCLE     = 196608;
    localparam longint ARC_SIXTH      = 32768;
    localparam longint ARC_THIRD      = 65536;
    localparam longint ARC_HALF       = 98304;
    localparam longint ARC_TWO_THIRDS = 131072;
    localparam int     HOLD_CYCLES    = 150;
    localparam int     IDLE_LIMIT     = 4000;
    localparam int     SETTLE_CYCLES  = 10;

    typedef struct packed {
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
    } rgb_t;

    // Tracks the register copy, predicts each color and checks results in order
    class color_checker;
        logic [LVL_W-1:0] sat;
        logic [LVL_W-1:0] light;
        logic [CNT_W-1:0] count;
        logic [CFG_W-1:0] stops_lo;
        logic [CFG_W-1:0] stops_hi;
        rgb_t             colors_due[$];
        int               errors;

        function new();
            sat      = SAT_RST;
            light    = LIGHT_RST;
            count    = COUNT_RST;
            stops_lo = '0;
            stops_hi = '0;
            errors   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_SATURATION: sat = data[LVL_W-1:0];
                REG_LIGHTNESS:  light = data[LVL_W-1:0];
                REG_HUE_COUNT:  count = data[CNT_W-1:0];
                REG_TABLE_LOW:  stops_lo = data;
                REG_TABLE_HIGH: stops_hi = data;
                default: ;
            endcase
        endfunction

        function longint unsigned stop_hue(int unsigned i);
            logic [CFG_W-1:0]  word;
            logic [STOP_W-1:0] v;
            word = (i < 4) ? stops_lo : stops_hi;
            v    = word[(i % 4) * STOP_W +: STOP_W] & HUE_MASK;
            return {48'd0, v};
        endfunction

        // One channel; t in 1/196608 units, q and p in 1/65025 units
        function logic [LVL_W-1:0] channel_level(longint t, longint unsigned qv,
                                                 longint unsigned pv);
            longint unsigned num;
            if (t < 0)
                t += ARC_CIRCLE;
            if (t > ARC_CIRCLE)
                t -= ARC_CIRCLE;
            if (t < ARC_SIXTH) begin
                num = pv * ARC_SIXTH + (qv - pv) * t;
                return LVL_W'(num / (255 * ARC_SIXTH));
            end
            if (t < ARC_HALF)
                return LVL_W'(qv / 255);
            if (t < ARC_TWO_THIRDS) begin
                num = pv * ARC_SIXTH + (qv - pv) * (ARC_TWO_THIRDS - t);
                return LVL_W'(num / (255 * ARC_SIXTH));
            end
            return LVL_W'(pv / 255);
        endfunction

        function rgb_t gradient_color(logic [POS_W-1:0] pos);
            longint unsigned n, prod, seg, frac, a, b, hue, s, l, qv, pv;
            longint          t3;
            rgb_t            c;
            n = count;
            if (n == 0)
                n = 1;
            if (n > MAX_HUES)
                n = MAX_HUES;
            prod = pos * n;
            seg  = prod >> 16;
            frac = prod & 64'hFFFF;
            a = stop_hue(seg % n);
            b = stop_hue((seg + 1) % n);
            // a smaller second stop goes forward around the circle
            if (b >= a) begin
                hue = a + ((frac * (b - a)) >> 16);
            end else begin
                hue = a + ((frac * (65536 - a + b)) >> 16);
                if (hue > 65536)
                    hue -= 65536;
            end
            s = sat;
            l = light;
            if (s == 0) begin
                c.red   = light;
                c.green = light;
                c.blue  = light;
                return c;
            end
            if (l <= 127)
                qv = l * (255 + s);
            else
                qv = 255 * l + 255 * s - l * s;
            pv = 510 * l - qv;
            t3 = 3 * hue;
            c.red   = channel_level(t3 + ARC_THIRD, qv, pv);
            c.green = channel_level(t3, qv, pv);
            c.blue  = channel_level(t3 - ARC_THIRD, qv, pv);
            return c;
        endfunction

        function void note_position(logic [POS_W-1:0] pos);
            colors_due.push_back(gradient_color(pos));
        endfunction

        function void check_color(rgb_t got);
            rgb_t want;
            if (colors_due.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: r=%0d g=%0d b=%0d",
                         $time, got.red, got.green, got.blue);
                return;
            end
            want = colors_due.pop_front();
            if (got.red !== want.red) begin
                errors++;
                $display("%0t: red mismatch: expected %0d actual %0d",
                         $time, want.red, got.red);
            end
            if (got.green !== want.green) begin
                errors++;
                $display("%0t: green mismatch: expected %0d actual %0d",
                         $time, want.green, got.green);
            end
            if (got.blue !== want.blue) begin
                errors++;
                $display("%0t: blue mismatch: expected %0d actual %0d",
                         $time, want.blue, got.blue);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [POS_W-1:0]     s_position;
    logic                 m_valid;
    logic                 m_ready;
    logic [LVL_W-1:0]     m_red_level;
    logic [LVL_W-1:0]     m_green_level;
    logic [LVL_W-1:0]     m_blue_level;

    color_checker chk = new();
    bit           src_fast;
    bit           hold_request;
    int           idle_cycles;

    hue_gradient_to_rgb_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one position after a random gap and wait until it is taken
    task automatic send_position(logic [POS_W-1:0] pos);
        int gap;
        gap = src_fast ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_position <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chk.note_position(pos);
    endtask

    // Stop offering, wait for every color to come back, then let the pipe settle
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (chk.colors_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        chk.set_reg(idx, data);
        @(posedge aclk);
    endtask

    // Full register set, written only with the pipeline empty
    task automatic set_colors(logic [LVL_W-1:0] sat, logic [LVL_W-1:0] light,
                              logic [CNT_W-1:0] count, logic [CFG_W-1:0] lo,
                              logic [CFG_W-1:0] hi);
        drain_and_settle();
        write_reg(REG_SATURATION, {56'd0, sat});
        write_reg(REG_LIGHTNESS, {56'd0, light});
        write_reg(REG_HUE_COUNT, {60'd0, count});
        write_reg(REG_TABLE_LOW, lo);
        write_reg(REG_TABLE_HIGH, hi);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [LVL_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd127;
            3: return 8'd128;
            default: return LVL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_stops();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'h0001_FFFF_8000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Result side: random back-pressure, with one long hold when asked
    initial begin : result_sink
        int stall;
        int taken;
        bit snk_fast;
        taken    = 0;
        snk_fast = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 40 == 0)
                snk_fast = ($urandom_range(0, 3) == 0);
            stall = snk_fast ? 0 : $urandom_range(0, 14);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            chk.check_color('{m_red_level, m_green_level, m_blue_level});
            taken++;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int               phase;
        int               k;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        idle_cycles  = 0;
        src_fast     = 1'b0;
        hold_request = 1'b0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_SATURATION;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_position  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: all stops at zero, lightness just above half
        send_position(16'h0000);
        send_position(16'hFFFF);
        send_position(16'h8000);
        send_position(16'h0001);

        // Zero saturation gives grey
        set_colors(8'd0, 8'd77, 4'd3, 64'hFEDC_BA98_7654_3210, 64'h0);
        send_position(16'h1111);
        send_position(16'hEEEE);

        // Wrap past one; hue lands exactly on one at 0x4000
        set_colors(8'd255, 8'd255, 4'd2, 64'h0000_0000_0001_FFFF, 64'h0);
        send_position(16'h4000);
        send_position(16'h7FFF);
        send_position(16'hC000);
        send_position(16'hFFFF);

        // Zero hue count acts as one stop
        set_colors(8'd200, 8'd50, 4'd0, 64'h0000_0000_0000_5555, 64'hFFFF_FFFF_FFFF_FFFF);
        send_position(16'h0000);
        send_position(16'hFFFF);
        send_position(16'h1234);

        // Count above the table size saturates; lightness at the q/p boundary
        set_colors(8'd128, 8'd127, 4'd15, 64'h2AAA_D555_0000_FFFF, 64'h8000_4000_C000_1234);
        send_position(16'hFFFF);
        send_position(16'hE000);
        send_position(16'h2000);
        send_position(16'h0000);
        send_position(16'h9FFF);

        // Full table, black
        set_colors(8'd255, 8'd0, 4'd8, 64'h1000_3000_5000_7000, 64'h9000_B000_D000_F000);
        send_position(16'h5A5A);
        send_position(16'hA5A5);

        // Random settings, each phase drained before the next write
        for (phase = 0; phase < 8; phase++) begin
            cnt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 15))
                                              : CNT_W'($urandom_range(1, 8));
            set_colors(pick_level(), pick_level(), cnt, pick_stops(), pick_stops());
            if (phase == 2 || phase == 5)
                hold_request = 1'b1;
            for (k = 0; k < 110; k++) begin
                if (k % 30 == 0)
                    src_fast = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 9))
                    0: pos = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    // near a segment boundary for power-of-two counts
                    1: pos = 16'(($urandom_range(1, 7) << 13) + $urandom_range(0, 2) - 1);
                    default: pos = 16'($urandom);
                endcase
                send_position(pos);
            end
        end

        drain_and_settle();
        if (chk.errors == 0 && chk.colors_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
